// ===== rtl/bbpd_pkg.sv =====
package bbpd_pkg;

	// One decoded sequence: either a single mapped byte or 1..4 raw bytes.
	typedef struct packed {
		logic [3:0][7:0] data;    // byte 0 goes out first
		logic [1:0]      cnt_m1;  // number of results minus one
		logic            mapped;
		logic            last;    // sequence closed the piece
	} job_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] data;
	} map_t;

	localparam int unsigned CP_W = 21;

	// Inverse of the byte-to-unicode table.
	function automatic map_t bbpd_lookup(input logic [CP_W-1:0] cp);
		map_t       m;
		logic [6:0] n;
		n      = cp[6:0];
		m.hit  = 1'b0;
		m.data = cp[7:0];
		if ((cp >= 21'h21 && cp <= 21'h7E) || (cp >= 21'hA1 && cp <= 21'hAC) ||
		    (cp >= 21'hAE && cp <= 21'hFF)) begin
			m.hit = 1'b1;
		end else if (cp >= 21'd256 && cp < 21'd324) begin
			m.hit = 1'b1;
			// excluded bytes in ascending order: 0x00-0x20, 0x7F-0xA0, 0xAD
			if (n < 7'd33) begin
				m.data = {1'b0, n};
			end else if (n < 7'd67) begin
				m.data = {1'b0, n} + 8'h5E;
			end else begin
				m.data = 8'hAD;
			end
		end
		return m;
	endfunction

endpackage

// ===== rtl/bbpd_front.sv =====
module bbpd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_byte,
	input  logic                in_last,
	output logic                push,
	output bbpd_pkg::job_t      push_job,
	input  logic                q_full
);
	import bbpd_pkg::*;

	logic [7:0]      held_q [3];
	logic [1:0]      held_cnt_q;
	logic [2:0]      seq_len_q;
	logic [CP_W-1:0] accum_q;

	logic            open_seq;
	logic [2:0]      lead_len;
	logic [CP_W-1:0] lead_cp;
	logic [CP_W-1:0] cont_cp;
	logic [CP_W-1:0] cp;
	logic [2:0]      nbytes;
	logic            done;
	logic            accept;
	logic [3:0][7:0] raw;
	map_t            map;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign open_seq = (seq_len_q != 3'd0);

	always_comb begin
		priority if (!in_byte[7]) begin
			lead_len = 3'd1;
			lead_cp  = {13'd0, in_byte};
		end else if (in_byte[7:5] == 3'b110) begin
			lead_len = 3'd2;
			lead_cp  = {16'd0, in_byte[4:0]};
		end else if (in_byte[7:4] == 4'b1110) begin
			lead_len = 3'd3;
			lead_cp  = {17'd0, in_byte[3:0]};
		end else if (in_byte[7:3] == 5'b11110) begin
			lead_len = 3'd4;
			lead_cp  = {18'd0, in_byte[2:0]};
		end else begin
			// bad lead: one byte, code point zero
			lead_len = 3'd1;
			lead_cp  = '0;
		end
	end

	always_comb begin
		cont_cp = {accum_q[CP_W-7:0], in_byte[5:0]};
		if (open_seq) begin
			nbytes = {1'b0, held_cnt_q} + 3'd1;
			cp     = cont_cp;
			done   = (nbytes >= seq_len_q) || in_last || (nbytes == 3'd4);
			raw[0] = (held_cnt_q > 2'd0) ? held_q[0] : in_byte;
			raw[1] = (held_cnt_q > 2'd1) ? held_q[1] : in_byte;
			raw[2] = (held_cnt_q > 2'd2) ? held_q[2] : in_byte;
			raw[3] = in_byte;
		end else begin
			nbytes = 3'd1;
			cp     = lead_cp;
			done   = (lead_len == 3'd1) || in_last;
			raw    = {4{in_byte}};
		end
		map = bbpd_lookup(cp);
		push_job.data   = raw;
		push_job.mapped = map.hit;
		push_job.last   = in_last;
		if (map.hit) begin
			push_job.data[0] = map.data;
			push_job.cnt_m1  = 2'd0;
		end else begin
			push_job.cnt_m1  = 2'(nbytes - 3'd1);
		end
	end

	assign push = accept && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= '0;
			seq_len_q  <= '0;
			accum_q    <= '0;
		end else if (accept) begin
			if (done) begin
				held_cnt_q <= '0;
				seq_len_q  <= '0;
				accum_q    <= '0;
			end else if (!open_seq) begin
				held_cnt_q <= 2'd1;
				seq_len_q  <= lead_len;
				accum_q    <= lead_cp;
			end else begin
				held_cnt_q <= held_cnt_q + 2'd1;
				accum_q    <= cont_cp;
			end
		end
	end

	// an open sequence never holds three bytes when another one is stored
	always_ff @(posedge clk) begin
		if (accept && !done) begin
			held_q[held_cnt_q] <= in_byte;
		end
	end

endmodule

// ===== rtl/bbpd_queue.sv =====
module bbpd_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bbpd_pkg::job_t push_job,
	output logic           full,
	output logic           head_valid,
	output bbpd_pkg::job_t head_job,
	input  logic           pop
);
	import bbpd_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	job_t          mem [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = mem[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_job;
		end
	end

endmodule

// ===== rtl/bbpd_back.sv =====
module bbpd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	input  bbpd_pkg::job_t job,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_byte,
	output logic           out_mapped,
	output logic           out_run_last,
	output logic           out_piece_done
);
	import bbpd_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       mapped_q;
	logic       run_last_q;
	logic       piece_done_q;
	logic       load;
	logic       job_end;

	assign load    = job_valid && (!valid_q || out_ready);
	assign job_end = (idx_q == job.cnt_m1);
	assign pop     = load && job_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= job_end ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q       <= job.data[idx_q];
			mapped_q     <= job.mapped;
			run_last_q   <= job_end;
			piece_done_q <= job_end && job.last;
		end
	end

	assign out_valid      = valid_q;
	assign out_byte       = byte_q;
	assign out_mapped     = mapped_q;
	assign out_run_last   = run_last_q;
	assign out_piece_done = piece_done_q;

endmodule

// ===== rtl/byte_level_bpe_piece_decoder_unit.sv =====
// channel  dir  tdata            tuser                      tlast
// s_axis   in   in_byte [7:0]    -                          piece_end
// m_axis   out  out_byte [7:0]   [0] was_mapped [1] run_last piece_done
//
// One input byte per cycle while the job queue has room; decoding of a byte
// finishes in the cycle it is taken. The back end sends one result per cycle
// while m_axis is ready, so a raw passthrough of n bytes gives n results.
// A result goes through the job queue and then the output register to m_axis.
// Reset clears the open sequence, the queue and the output register.
// A stall on m_axis fills the queue; s_axis tready drops only when it is full.
module byte_level_bpe_piece_decoder_unit #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic [1:0] m_axis_tuser,   // [0] was_mapped, [1] run_last
	output logic       m_axis_tlast
);
	import bbpd_pkg::*;

	logic push;
	job_t push_job;
	logic q_full;
	logic head_valid;
	job_t head_job;
	logic pop;

	bbpd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.push     (push),
		.push_job (push_job),
		.q_full   (q_full)
	);

	bbpd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop)
	);

	bbpd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.job_valid      (head_valid),
		.job            (head_job),
		.pop            (pop),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_byte       (m_axis_tdata),
		.out_mapped     (m_axis_tuser[0]),
		.out_run_last   (m_axis_tuser[1]),
		.out_piece_done (m_axis_tlast)
	);

	a_piece_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1])
		else $error("piece end not on the last result of its byte");

	a_mapped_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[1])
		else $error("mapped code point gave more than one result");

	a_full_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> head_valid)
		else $error("input stalled with an empty job queue");

endmodule
